/* src/lpd_pkg.sv */
// Package for the length-prefixed string deframer.
// Holds the item types, code enums and header constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

	typedef enum logic {
		OP_DATA = 1'b0,
		OP_EOS  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_TRUNC = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_LEN  = 3'b010,
		PH_DATA = 3'b100
	} phase_t;

	localparam logic [7:0] LongMark = 8'd253;
	localparam logic [7:0] LongBias = 8'd251;

	typedef struct packed {
		op_t        operation;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic idle;
		logic data;
		logic count_zero;
	} lpd_status_t;

endpackage

`default_nettype wire

/* src/lpd_core.sv */
// Deframer state machine: header decode, length assembly and payload count.
// Depends on lpd_pkg; the state advances only when step is high.
`timescale 1ns / 1ps
`default_nettype none

module lpd_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire lpd_pkg::req_t      item,
	output logic                    has_res,
	output lpd_pkg::rsp_t           res,
	output lpd_pkg::lpd_status_t    status
);
	import lpd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  left_q, left_d;
	logic [31:0] cnt_q, cnt_d;
	logic [31:0] cnt_shift;
	logic [31:0] cnt_dec;
	logic [7:0]  bias_diff;

	assign cnt_shift = {cnt_q[23:0], item.data_byte};
	assign cnt_dec   = cnt_q - 32'd1;
	assign bias_diff = item.data_byte - LongBias;

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		cnt_d   = cnt_q;
		has_res = 1'b0;
		res     = '{kind: KIND_BYTE, payload_byte: 8'd0, last: 1'b0};
		case (phase_q)
			PH_LEN: begin
				if (item.operation == OP_EOS) begin
					phase_d  = PH_IDLE;
					left_d   = 3'd0;
					cnt_d    = 32'd0;
					has_res  = 1'b1;
					res.kind = KIND_TRUNC;
				end else if (left_q == 3'd0) begin
					phase_d = PH_IDLE;
				end else begin
					cnt_d  = cnt_shift;
					left_d = left_q - 3'd1;
					if (left_q == 3'd1) begin
						if (cnt_shift == 32'd0) begin
							phase_d  = PH_IDLE;
							has_res  = 1'b1;
							res.kind = KIND_EMPTY;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
			end
			PH_DATA: begin
				if (item.operation == OP_EOS) begin
					phase_d  = PH_IDLE;
					left_d   = 3'd0;
					cnt_d    = 32'd0;
					has_res  = 1'b1;
					res.kind = KIND_TRUNC;
				end else if (cnt_q == 32'd0) begin
					phase_d = PH_IDLE;
				end else begin
					cnt_d            = cnt_dec;
					has_res          = 1'b1;
					res.kind         = KIND_BYTE;
					res.payload_byte = item.data_byte;
					res.last         = (cnt_dec == 32'd0);
					if (cnt_dec == 32'd0) begin
						phase_d = PH_IDLE;
					end
				end
			end
			default: begin
				if (item.operation == OP_EOS) begin
					has_res  = 1'b1;
					res.kind = KIND_END;
				end else if (item.data_byte >= LongMark) begin
					left_d  = bias_diff[2:0];
					cnt_d   = 32'd0;
					phase_d = PH_LEN;
				end else if (item.data_byte == 8'd0) begin
					phase_d  = PH_IDLE;
					has_res  = 1'b1;
					res.kind = KIND_EMPTY;
				end else begin
					cnt_d   = {24'd0, item.data_byte};
					phase_d = PH_DATA;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			left_q  <= 3'd0;
			cnt_q   <= 32'd0;
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			cnt_q   <= cnt_d;
		end
	end

	assign status.idle       = (phase_q != PH_LEN) && (phase_q != PH_DATA);
	assign status.data       = (phase_q == PH_DATA);
	assign status.count_zero = (cnt_q == 32'd0);

endmodule

`default_nettype wire

/* src/length_prefix_deframer.sv */
// An accepted item is held in the input register and its result, if any, is
// presented from the result register once the item advances out of the input register.
// Throughput: one item per cycle unless rsp_stall holds a result; header decode and the
// 32-bit payload count update fit in the single stage between input and result registers.
// Reset: arst_n clears the valid flags and the deframer state to idle.
// Top level of the length-prefixed string deframer; instantiates lpd_core, uses lpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module length_prefix_deframer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire lpd_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output lpd_pkg::rsp_t      rsp
);
	import lpd_pkg::*;

	req_t        item_s1;
	logic        valid_s1;
	rsp_t        rsp_q;
	logic        rsp_valid_q;
	logic        has_res;
	rsp_t        res;
	lpd_status_t status;
	logic        advance;
	logic        load_s1;

	assign advance   = valid_s1 && (!has_res || !rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign load_s1   = req_valid && !req_stall;

	lpd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (item_s1),
		.has_res (has_res),
		.res     (res),
		.status  (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && has_res) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= req;
		end
		if (advance && has_res) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("input stalled with no item held");

	a_last_only_on_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.last) |-> (rsp.kind == KIND_BYTE))
		else $error("last flag on a result that is not a payload byte");

	a_trunc_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && has_res && res.kind == KIND_TRUNC) |=> status.idle)
		else $error("deframer not idle after a truncation");

	a_data_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		status.data |-> !status.count_zero)
		else $error("payload phase with a zero byte count");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && has_res && res.last) |=> status.idle)
		else $error("deframer not idle after the final payload byte");

endmodule

`default_nettype wire
